>>> rtl/ckt_pkg.sv
// Shared types and codes for the compacting key table.
// No dependencies; imported by every module of the block.
`default_nettype none

package ckt_pkg;

	localparam int CKT_DEPTH = 256;
	localparam int KEY_W     = 32;
	localparam int CNT_OUT_W = 9;

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_SEARCH = 2'd1,
		OP_MODIFY = 2'd2,
		OP_DELETE = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_ADDED     = 3'd0,
		ST_FOUND     = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_MODIFIED  = 3'd3,
		ST_DELETED   = 3'd4,
		ST_FULL      = 3'd5
	} status_t;

	// Broadcast write enables from the controller to every cell
	typedef struct packed {
		logic ins_en;
		logic mod_en;
		logic del_en;
	} cell_ctl_t;

	// Scan token handed from cell to cell
	typedef struct packed {
		logic act;
		logic hit;
	} token_t;

endpackage

`default_nettype wire

>>> rtl/ckt_cell.sv
// One storage cell of the key table: holds one entry, compares it as the scan
// token passes and forwards the token to its neighbor. Depends on ckt_pkg.
`default_nettype none

module ckt_cell #(
	parameter int DEPTH = 256,
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic [IW-1:0]            idx,
	input  wire ckt_pkg::cell_ctl_t       ctl,
	input  wire logic [CW-1:0]            count,
	input  wire logic [IW-1:0]            del_pos,
	input  wire logic [ckt_pkg::KEY_W-1:0] key,
	input  wire logic [ckt_pkg::KEY_W-1:0] new_value,
	input  wire logic [ckt_pkg::KEY_W-1:0] next_entry,
	input  wire ckt_pkg::token_t          tok_in,
	input  wire logic [IW-1:0]            pos_in,
	output logic [ckt_pkg::KEY_W-1:0]     entry,
	output ckt_pkg::token_t               tok_out,
	output logic [IW-1:0]                 pos_out
);
	import ckt_pkg::*;

	localparam int WW = CW + 1;

	logic [KEY_W-1:0] entry_q;
	token_t           tok_q;
	logic [IW-1:0]    pos_q;
	logic             in_range;
	logic             match;
	logic             ins_here;
	logic             shift_here;

	assign in_range   = WW'(idx) < WW'(count);
	assign match      = tok_in.act && in_range && (entry_q == key);
	assign ins_here   = ctl.ins_en && (WW'(idx) == WW'(count));
	// close the gap left by a delete: take the upper neighbor's value
	assign shift_here = ctl.del_en && (idx >= del_pos) && ((WW'(idx) + WW'(1)) < WW'(count));

	always_ff @(posedge clk) begin
		if (ins_here) begin
			entry_q <= key;
		end else if (shift_here) begin
			entry_q <= next_entry;
		end else if (ctl.mod_en && match) begin
			entry_q <= new_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.act <= tok_in.act;
			tok_q.hit <= tok_in.act && (tok_in.hit || match);
		end
	end

	// keep the latest match position seen so far
	always_ff @(posedge clk) begin
		pos_q <= match ? idx : pos_in;
	end

	assign entry   = entry_q;
	assign tok_out = tok_q;
	assign pos_out = pos_q;

endmodule

`default_nettype wire

>>> rtl/ckt_ctrl.sv
// Sequencer of the key table: takes requests, launches the scan token down the
// cell chain, applies insert, modify and delete, and holds the response. Depends on ckt_pkg.
`default_nettype none

module ckt_ctrl #(
	parameter int DEPTH = 256,
	parameter int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1,
	parameter int CW    = $clog2(DEPTH + 1)
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          req_valid,
	output logic                               req_stall,
	input  wire logic [1:0]                    opcode,
	input  wire logic signed [ckt_pkg::KEY_W-1:0] key,
	input  wire logic signed [ckt_pkg::KEY_W-1:0] new_value,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic [2:0]                         status,
	output logic [ckt_pkg::CNT_OUT_W-1:0]      entry_count,
	output ckt_pkg::cell_ctl_t                 ctl,
	output logic [CW-1:0]                      count,
	output logic [IW-1:0]                      del_pos,
	output logic [ckt_pkg::KEY_W-1:0]          bc_key,
	output logic [ckt_pkg::KEY_W-1:0]          bc_value,
	output ckt_pkg::token_t                    tok_launch,
	input  wire ckt_pkg::token_t               tok_end,
	input  wire logic [IW-1:0]                 pos_end
);
	import ckt_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EXEC = 4'b0010,
		S_SCAN = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t           state_q;
	op_t              op_q;
	logic [KEY_W-1:0] key_q;
	logic [KEY_W-1:0] value_q;
	logic [CW-1:0]    count_q;
	status_t          status_q;
	logic             full;
	logic             req_acc;

	assign req_acc   = req_valid && !req_stall;
	assign req_stall = (state_q != S_IDLE);
	assign full      = (count_q == CW'(DEPTH));

	always_comb begin
		ctl        = '0;
		tok_launch = '0;
		// cell 0 sees the token while still in S_EXEC
		ctl.mod_en = ((state_q == S_EXEC) || (state_q == S_SCAN)) && (op_q == OP_MODIFY);
		if (state_q == S_EXEC) begin
			ctl.ins_en     = (op_q == OP_INSERT) && !full;
			tok_launch.act = (op_q != OP_INSERT);
		end
		ctl.del_en = (state_q == S_SCAN) && tok_end.act && tok_end.hit && (op_q == OP_DELETE);
	end

	assign count    = count_q;
	assign del_pos  = pos_end;
	assign bc_key   = key_q;
	assign bc_value = value_q;

	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q    <= op_t'(opcode);
			key_q   <= key;
			value_q <= new_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			status_q <= ST_ADDED;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) state_q <= S_EXEC;
				end
				S_EXEC: begin
					if (op_q == OP_INSERT) begin
						if (full) begin
							status_q <= ST_FULL;
						end else begin
							status_q <= ST_ADDED;
							count_q  <= count_q + CW'(1);
						end
						state_q <= S_OUT;
					end else begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					// wait for the token to leave the last cell
					if (tok_end.act) begin
						if (!tok_end.hit) begin
							status_q <= ST_NOT_FOUND;
						end else begin
							case (op_q)
								OP_SEARCH: status_q <= ST_FOUND;
								OP_MODIFY: status_q <= ST_MODIFIED;
								default: begin
									status_q <= ST_DELETED;
									count_q  <= count_q - CW'(1);
								end
							endcase
						end
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!rsp_stall) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid   = (state_q == S_OUT);
	assign status      = status_q;
	assign entry_count = CNT_OUT_W'(count_q);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("fill count above capacity");

	a_del_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.del_en |-> (count_q != '0))
		else $error("delete issued on an empty table");

	a_token_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		tok_end.act |-> (state_q == S_SCAN))
		else $error("scan token left the chain outside a scan");

	a_full_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EXEC && op_q == OP_INSERT && full) |=> $stable(count_q))
		else $error("insert into a full table changed the count");

endmodule

`default_nettype wire

>>> rtl/compacting_key_table.sv
// Compacting key table: a packed list of up to DEPTH keys in a chain of cells.
// Insert goes from S_EXEC straight to S_OUT; search, modify and delete wait in
// S_SCAN until the scan token has walked the full cell chain.
// One request at a time: a new request is taken only in S_IDLE, once the
// previous response has been accepted.
// Reset (arst_n low) clears the fill count and control; entries hold no reset.
`default_nettype none

module compacting_key_table #(
	parameter int DEPTH = ckt_pkg::CKT_DEPTH
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             req_valid,
	output logic                                  req_stall,
	input  wire logic [1:0]                       opcode,
	input  wire logic signed [ckt_pkg::KEY_W-1:0] key,
	input  wire logic signed [ckt_pkg::KEY_W-1:0] new_value,
	output logic                                  rsp_valid,
	input  wire logic                             rsp_stall,
	output logic [2:0]                            status,
	output logic [ckt_pkg::CNT_OUT_W-1:0]         entry_count
);
	import ckt_pkg::*;

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	cell_ctl_t        ctl;
	logic [CW-1:0]    count;
	logic [IW-1:0]    del_pos;
	logic [KEY_W-1:0] bc_key;
	logic [KEY_W-1:0] bc_value;
	token_t           tok_launch;

	logic [KEY_W-1:0] entry [DEPTH];
	token_t           tok   [DEPTH+1];
	logic [IW-1:0]    pos   [DEPTH+1];

	assign tok[0] = tok_launch;
	assign pos[0] = '0;

	ckt_ctrl #(.DEPTH(DEPTH), .IW(IW), .CW(CW)) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.opcode      (opcode),
		.key         (key),
		.new_value   (new_value),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.entry_count (entry_count),
		.ctl         (ctl),
		.count       (count),
		.del_pos     (del_pos),
		.bc_key      (bc_key),
		.bc_value    (bc_value),
		.tok_launch  (tok_launch),
		.tok_end     (tok[DEPTH]),
		.pos_end     (pos[DEPTH])
	);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [KEY_W-1:0] next_entry;
		// the top cell never shifts; feed it anything
		if (i == DEPTH - 1) begin : g_top
			assign next_entry = bc_key;
		end else begin : g_mid
			assign next_entry = entry[i+1];
		end

		ckt_cell #(.DEPTH(DEPTH), .IW(IW), .CW(CW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.idx        (IW'(i)),
			.ctl        (ctl),
			.count      (count),
			.del_pos    (del_pos),
			.key        (bc_key),
			.new_value  (bc_value),
			.next_entry (next_entry),
			.tok_in     (tok[i]),
			.pos_in     (pos[i]),
			.entry      (entry[i]),
			.tok_out    (tok[i+1]),
			.pos_out    (pos[i+1])
		);
	end

endmodule

`default_nettype wire

>>> bench/ckt_checker.sv
`timescale 1ns / 1ps
// Checker for the compacting key table: watches both channels, predicts each response
// from its own copy of the table and compares status and entry count in order.
// Depends on ckt_pkg for the opcode and status codes.

module ckt_checker #(
	parameter int DEPTH = ckt_pkg::CKT_DEPTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic [1:0]  opcode,
	input  logic [31:0] key,
	input  logic [31:0] new_value,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic [2:0]  status,
	input  logic [8:0]  entry_count,
	output int          fail_count,
	output int          pending
);
	import ckt_pkg::*;

	typedef struct {
		status_t    st;
		logic [8:0] cnt;
	} table_reply_t;

	logic [31:0]  slots [DEPTH];
	int unsigned  used;
	table_reply_t replies [$];
	table_reply_t want;

	initial begin
		fail_count = 0;
		pending = 0;
		used = 0;
	end

	// Apply one request to the shadow table and return the response it must produce
	function automatic table_reply_t apply_request(op_t op, logic [31:0] k, logic [31:0] v);
		table_reply_t r;
		int hit_pos;
		int i;
		hit_pos = -1;
		case (op)
			OP_INSERT: begin
				if (used >= DEPTH) begin
					r.st = ST_FULL;
				end else begin
					slots[used] = k;
					used++;
					r.st = ST_ADDED;
				end
			end
			OP_SEARCH: begin
				for (i = 0; i < used; i++)
					if (slots[i] == k)
						hit_pos = i;
				r.st = (hit_pos >= 0) ? ST_FOUND : ST_NOT_FOUND;
			end
			OP_MODIFY: begin
				for (i = 0; i < used; i++)
					if (slots[i] == k) begin
						slots[i] = v;
						hit_pos = i;
					end
				r.st = (hit_pos >= 0) ? ST_MODIFIED : ST_NOT_FOUND;
			end
			default: begin
				// only the last match goes; later entries close the gap
				for (i = 0; i < used; i++)
					if (slots[i] == k)
						hit_pos = i;
				if (hit_pos < 0) begin
					r.st = ST_NOT_FOUND;
				end else begin
					for (i = hit_pos; i + 1 < used; i++)
						slots[i] = slots[i + 1];
					used--;
					r.st = ST_DELETED;
				end
			end
		endcase
		r.cnt = 9'(used);
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used = 0;
			replies.delete();
		end else begin
			if (req_valid && !req_stall)
				replies.push_back(apply_request(op_t'(opcode), key, new_value));
			if (rsp_valid && !rsp_stall) begin
				if (replies.size() == 0) begin
					$display("%0t: unexpected response, status %0d entry_count %0d",
						$time, status, entry_count);
					fail_count++;
				end else begin
					want = replies.pop_front();
					if (status !== want.st) begin
						$display("%0t: status mismatch, expected %0d actual %0d",
							$time, want.st, status);
						fail_count++;
					end
					if (entry_count !== want.cnt) begin
						$display("%0t: entry_count mismatch, expected %0d actual %0d",
							$time, want.cnt, entry_count);
						fail_count++;
					end
				end
			end
		end
		pending = replies.size();
	end

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps
// Top of the compacting key table bench: clock, reset, request stimulus and verdict.
// Depends on ckt_pkg, the compacting_key_table RTL and ckt_checker.

module tb_top;
	import ckt_pkg::*;

	localparam int TBL_DEPTH = CKT_DEPTH;
	localparam int CYCLE_LIMIT = 2_000_000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        req_valid = 1'b0;
	logic        req_stall;
	logic [1:0]  opcode = OP_INSERT;
	logic [31:0] key = '0;
	logic [31:0] new_value = '0;
	logic        rsp_valid;
	logic        rsp_stall = 1'b0;
	logic [2:0]  status;
	logic [8:0]  entry_count;

	int          fail_count;
	int          pending;
	int          snd_idle_pct = 31;
	int          rcv_stall_pct = 60;
	int          cycle_cnt = 0;
	logic [31:0] key_pool [8];

	always #2 clk = ~clk;

	compacting_key_table #(.DEPTH(TBL_DEPTH)) dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.opcode     (opcode),
		.key        (key),
		.new_value  (new_value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.entry_count(entry_count)
	);

	ckt_checker #(.DEPTH(TBL_DEPTH)) tbl_chk (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.opcode     (opcode),
		.key        (key),
		.new_value  (new_value),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.status     (status),
		.entry_count(entry_count),
		.fail_count (fail_count),
		.pending    (pending)
	);

	always @(posedge clk)
		rsp_stall <= ($urandom_range(99) < rcv_stall_pct);

	initial begin
		while (cycle_cnt < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_cnt++;
		end
		$display("** compacting_key_table: FAILED **");
		$finish;
	end

	// Hold the request until it is taken; valid stays high into the next request
	task automatic send_req(input op_t op, input logic [31:0] k, input logic [31:0] v);
		while ($urandom_range(99) < snd_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		opcode    <= op;
		key       <= k;
		new_value <= v;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
	endtask

	// Mostly keys from a small pool so that search, modify and delete find matches
	function automatic logic [31:0] pick_key();
		if ($urandom_range(99) < 75)
			return key_pool[$urandom_range(7)];
		return $urandom();
	endfunction

	// Grow the table for the first grow_n requests, then drain it
	task automatic random_requests(input int n, input int grow_n);
		int   j;
		int   r;
		op_t  op;
		for (j = 0; j < n; j++) begin
			r = $urandom_range(99);
			if (j < grow_n)
				op = (r < 70) ? OP_INSERT : (r < 80) ? OP_SEARCH :
					(r < 90) ? OP_MODIFY : OP_DELETE;
			else
				op = (r < 10) ? OP_INSERT : (r < 25) ? OP_SEARCH :
					(r < 40) ? OP_MODIFY : OP_DELETE;
			send_req(op, pick_key(), $urandom_range(1) ? pick_key() : $urandom());
		end
	endtask

	initial begin
		key_pool[0] = 32'h8000_0000;
		key_pool[1] = 32'h7FFF_FFFF;
		key_pool[2] = 32'h0000_0000;
		key_pool[3] = 32'hFFFF_FFFF;
		for (int p = 4; p < 8; p++)
			key_pool[p] = $urandom();

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table: nothing to find
		send_req(OP_DELETE, 32'h0000_0000, 32'h0000_0000);
		send_req(OP_SEARCH, 32'h8000_0000, 32'hFFFF_FFFF);
		send_req(OP_MODIFY, 32'h7FFF_FFFF, 32'h1234_5678);
		// extremes, with a duplicate
		send_req(OP_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
		send_req(OP_INSERT, 32'h7FFF_FFFF, 32'h0000_0000);
		send_req(OP_INSERT, 32'hFFFF_FFFF, 32'h8000_0000);
		send_req(OP_INSERT, 32'h0000_0000, 32'h7FFF_FFFF);
		send_req(OP_INSERT, 32'h7FFF_FFFF, 32'h5555_5555);
		send_req(OP_INSERT, 32'h1234_5678, 32'hAAAA_AAAA);
		send_req(OP_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
		send_req(OP_SEARCH, 32'h0000_0001, 32'h0000_0000);
		// modify rewrites both copies
		send_req(OP_MODIFY, 32'h7FFF_FFFF, 32'hAAAA_AAAA);
		send_req(OP_SEARCH, 32'h7FFF_FFFF, 32'h0000_0000);
		// delete takes the later copy first
		send_req(OP_DELETE, 32'hAAAA_AAAA, 32'h0000_0000);
		send_req(OP_DELETE, 32'hAAAA_AAAA, 32'h0000_0000);
		send_req(OP_SEARCH, 32'hAAAA_AAAA, 32'h0000_0000);
		send_req(OP_DELETE, 32'h8000_0000, 32'h0000_0000);
		send_req(OP_DELETE, 32'h1234_5678, 32'h0000_0000);
		send_req(OP_MODIFY, 32'hFFFF_FFFF, 32'h8000_0000);
		send_req(OP_SEARCH, 32'h8000_0000, 32'h0000_0000);
		send_req(OP_DELETE, 32'h0000_0000, 32'h0000_0000);
		send_req(OP_SEARCH, 32'hFFFF_FFFF, 32'h0000_0000);

		random_requests(400, 300);
		snd_idle_pct  = 60;
		rcv_stall_pct = 31;
		random_requests(400, 300);
		snd_idle_pct  = 0;
		rcv_stall_pct = 0;
		random_requests(400, 300);

		req_valid <= 1'b0;
		// let the checker count the last request before polling
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TBL_DEPTH + 8) @(posedge clk);
		if (fail_count == 0)
			$display("** compacting_key_table: PASSED **");
		else
			$display("** compacting_key_table: FAILED **");
		$finish;
	end

endmodule
